[design/iae_pkg.sv]
`default_nettype none

package iae_pkg;

  // field widths of one transaction
  localparam int OP_W  = 3;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;

  localparam int IN_TDATA_W  = ((OP_W + IDX_W + VAL_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

  // result of one operation, ok in the lowest bit
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] data_out;
    logic                    ok;
  } res_t;

  localparam int OUT_TDATA_W = (($bits(res_t) + 7) / 8) * 8;

endpackage

`default_nettype wire

[design/iae_mem.sv]
`default_nettype none

module iae_mem
  import iae_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [VAL_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/iae_seq.sv]
`default_nettype none

module iae_seq
  import iae_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [OP_W-1:0]  op,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [VAL_W-1:0] val,
  output logic                  ready,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output res_t                  res,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic [VAL_W-1:0]      mem_wr_data,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  wire logic [VAL_W-1:0] mem_rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_GET  = 3'd4;
  localparam logic [2:0] S_FIND = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [VAL_W-1:0]  val_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              vld_r, vld_nxt;
  logic              ok_r, ok_nxt;
  logic [VAL_W-1:0]  data_r, data_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic [XW-1:0]     idx_x, fill_x, ptr_x;
  logic [CW-1:0]     idx_c, ptr_inc, ptr_dec, ptr_dec2;
  logic              not_full, idx_held;

  assign idx_x    = XW'(idx_r);
  assign fill_x   = XW'(fill_r);
  assign ptr_x    = XW'(ptr_r);
  assign idx_c    = idx_x[CW-1:0];
  assign ptr_inc  = ptr_r + CW'(1);
  assign ptr_dec  = ptr_r - CW'(1);
  assign ptr_dec2 = ptr_r - CW'(2);
  assign not_full = (fill_r < DEPTH_C);
  assign idx_held = (idx_x < fill_x);

  assign ready        = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.ok       = ok_r;
  assign res.data_out = data_r;
  assign res.position = pos_r;
  assign res.count    = CNT_W'(fill_r);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    vld_nxt     = 1'b0;
    ok_nxt      = ok_r;
    data_nxt    = data_r;
    pos_nxt     = pos_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = fill_r[AW-1:0];
    mem_wr_data = val_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ok_nxt    = 1'b0;
        data_nxt  = '0;
        pos_nxt   = '0;
        state_nxt = S_DONE;
        case (op_r)
          OP_APPEND: begin
            if (not_full) begin
              mem_wr_en = 1'b1;
              fill_nxt  = fill_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end
          OP_INSERT: begin
            if (not_full && (idx_x <= fill_x)) begin
              ptr_nxt   = fill_r;
              state_nxt = S_INS;
            end
          end
          OP_SET: begin
            if (idx_held) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = idx_c[AW-1:0];
              ok_nxt      = 1'b1;
            end
          end
          OP_GET: begin
            if (idx_held) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = idx_c[AW-1:0];
              state_nxt   = S_GET;
            end
          end
          OP_REMOVE: begin
            if (idx_held) begin
              ptr_nxt   = idx_c;
              state_nxt = S_REM;
            end
          end
          OP_FIND: begin
            ptr_nxt   = '0;
            state_nxt = S_FIND;
          end
          default: begin
          end
        endcase
      end

      // walk down from the top, moving each word one place up
      S_INS: begin
        if (vld_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ptr_inc[AW-1:0];
          mem_wr_data = mem_rd_data;
        end
        if (ptr_x > idx_x) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_dec[AW-1:0];
          ptr_nxt     = ptr_dec;
          vld_nxt     = 1'b1;
        end else if (!vld_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = idx_c[AW-1:0];
          mem_wr_data = val_r;
          fill_nxt    = fill_r + CW'(1);
          ok_nxt      = 1'b1;
          state_nxt   = S_DONE;
        end
      end

      // first word read is the one taken out, the rest move one place down
      S_REM: begin
        if (vld_r) begin
          if (ptr_dec == idx_c) begin
            data_nxt = mem_rd_data;
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_dec2[AW-1:0];
            mem_wr_data = mem_rd_data;
          end
        end
        if (ptr_r < fill_r) begin
          mem_rd_en = 1'b1;
          ptr_nxt   = ptr_inc;
          vld_nxt   = 1'b1;
        end else if (!vld_r) begin
          fill_nxt  = fill_r - CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_GET: begin
        data_nxt  = mem_rd_data;
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
      end

      S_FIND: begin
        if (vld_r && (mem_rd_data == val_r)) begin
          ok_nxt    = 1'b1;
          pos_nxt   = POS_W'(ptr_dec);
          state_nxt = S_DONE;
        end else if (ptr_r < fill_r) begin
          mem_rd_en = 1'b1;
          ptr_nxt   = ptr_inc;
          vld_nxt   = 1'b1;
        end else if (!vld_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && ready) begin
      op_r  <= op;
      idx_r <= idx;
      val_r <= val;
    end
    ptr_r  <= ptr_nxt;
    ok_r   <= ok_nxt;
    data_r <= data_nxt;
    pos_r  <= pos_nxt;
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count above capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |->
      (fill_r == $past(fill_r) + CW'(1) || fill_r + CW'(1) == $past(fill_r)))
    else $error("fill count moved by more than one");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("store read and write hit the same entry");

  a_fill_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_nxt != fill_r) |=> (state_r == S_DONE))
    else $error("fill count changed without finishing the operation");

endmodule

`default_nettype wire

[design/indexed_array_engine_core.sv]
// sequence: append, set and failed ops go from execute straight to done; get adds a read state;
//   insert and remove walk the store moving words, and find reads one stored word per cycle
//   until a match or the end of the list
// one operation at a time: the next transaction is taken in the cycle after the result
//   leaves the sequencer
// reset: rst_n synchronous active low clears the sequencer, fill count and output valid;
//   store contents are not cleared and need no clearing pass
`default_nettype none

module indexed_array_engine_core
  import iae_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // op[2:0], index[12:3], value[44:13]
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // ok[0], data_out[32:1], position[42:33],
                                                  // count[53:43]
);

  localparam int AW = $clog2(DEPTH);

  // input field unpacking
  logic [OP_W-1:0]  in_op;
  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_value;

  assign in_op    = in_tdata[OP_W-1:0];
  assign in_index = in_tdata[OP_W+IDX_W-1:OP_W];
  assign in_value = in_tdata[OP_W+IDX_W+VAL_W-1:OP_W+IDX_W];

  // sequencer to output register
  logic  seq_ready;
  logic  res_valid;
  logic  res_ready;
  res_t  res;

  // store port
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [VAL_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [VAL_W-1:0] mem_rd_data;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // a new transaction is taken only when the sequencer is idle
  assign in_tready = seq_ready;

  // the output register frees the sequencer while a result waits downstream
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && !out_tready);

  iae_seq #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_tvalid),
    .op          (in_op),
    .idx         (in_index),
    .val         (in_value),
    .ready       (seq_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  iae_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload loads only when the sequencer hands over a result
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

endmodule

`default_nettype wire

[verif/indexed_array_engine_core_test.sv]
`default_nettype none

module indexed_array_engine_core_test;
  import iae_pkg::*;

  localparam int DEPTH          = 1024;
  localparam int RAND_ITEMS     = 520;
  localparam int LAST_OPS       = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  // longest walk is a find over a full store, plus some margin
  localparam int TAIL_CYCLES    = DEPTH + 64;
  localparam int REPORT_MAX     = 10;

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  // typed-in expectation that travels with an input transaction
  typedef struct packed {
    logic pinned;
    res_t want;
  } item_note_t;

  // one row of the directed table
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             pinned;
    res_t             want;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  item_note_t item_note = '0;
  logic       idle_on   = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         fault_count = 0;

  // own copy of the list contents
  logic [VAL_W-1:0] held_words [DEPTH];
  int               held_count = 0;
  res_t             pending_results [$];
  dir_row_t         dir_table [$];
  logic [VAL_W-1:0] value_pool [8];

  indexed_array_engine_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // list behavior: applies one operation to the held words, returns the result
  function automatic res_t step_list(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                     input logic [VAL_W-1:0] val);
    res_t r;
    int   i;
    int   at;
    r  = '0;
    at = int'(idx);
    case (op)
      OP_APPEND: begin
        if (held_count < DEPTH) begin
          held_words[held_count] = val;
          held_count++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        // insert at the current count behaves as append
        if (held_count < DEPTH && at <= held_count) begin
          for (i = held_count; i > at; i--) held_words[i] = held_words[i-1];
          held_words[at] = val;
          held_count++;
          r.ok = 1'b1;
        end
      end
      OP_SET: begin
        if (at < held_count) begin
          held_words[at] = val;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (at < held_count) begin
          r.data_out = held_words[at];
          r.ok       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (at < held_count) begin
          r.data_out = held_words[at];
          for (i = at; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
          held_count--;
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        // first match wins
        for (i = 0; i < held_count; i++) begin
          if (!r.ok && held_words[i] == val) begin
            r.position = i[IDX_W-1:0];
            r.ok       = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = held_count[CNT_W-1:0];
    return r;
  endfunction

  // often pool values so finds hit and duplicates appear
  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return value_pool[$urandom_range(0, 7)];
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input int idx, input logic [VAL_W-1:0] val,
                         input int pinned, input int ok, input logic [VAL_W-1:0] data,
                         input int pos, input int cnt);
    dir_row_t row;
    row.op             = op;
    row.index          = idx[IDX_W-1:0];
    row.value          = val;
    row.pinned         = pinned[0];
    row.want.ok        = ok[0];
    row.want.data_out  = data;
    row.want.position  = pos[POS_W-1:0];
    row.want.count     = cnt[CNT_W-1:0];
    dir_table.push_back(row);
  endtask

  // drive one input transaction and hold it until the block takes it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic pinned, input res_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid        <= 1'b1;
    in_tdata         <= {{(IN_TDATA_W-OP_W-IDX_W-VAL_W){1'b0}}, val, idx, op};
    item_note.pinned <= pinned;
    item_note.want   <= want;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // stop sending and wait until every expected result is back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // scoreboard: predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t predicted;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = step_list(in_tdata[OP_W-1:0], in_tdata[OP_W +: IDX_W],
                              in_tdata[OP_W+IDX_W +: VAL_W]);
        // a typed-in row overrides the prediction, the state still advances
        pending_results.push_back(item_note.pinned ? item_note.want : predicted);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(res_t)-1:0];
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("unexpected result: ok=%0d data=%h pos=%0d count=%0d",
                     got.ok, got.data_out, got.position, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok || got.data_out !== want.data_out ||
              got.position !== want.position || got.count !== want.count) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("mismatch: expected ok=%0d data=%h pos=%0d count=%0d, got ok=%0d data=%h pos=%0d count=%0d",
                       want.ok, want.data_out, want.position, want.count,
                       got.ok, got.data_out, got.position, got.count);
          end
        end
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               n;
    int               live;
    int               roll;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;

    foreach (value_pool[k]) value_pool[k] = $urandom;

    // directed table, store empty at the start
    add_row(OP_GET,    0,    32'h0000_0000, 1, 0, 32'h0, 0, 0);
    add_row(OP_FIND,   0,    32'h0000_0000, 1, 0, 32'h0, 0, 0);
    add_row(OP_REMOVE, 0,    32'h0000_0000, 1, 0, 32'h0, 0, 0);
    add_row(OP_SET,    0,    32'h0000_0005, 1, 0, 32'h0, 0, 0);
    // insert past the end
    add_row(OP_INSERT, 1,    32'h0000_0007, 1, 0, 32'h0, 0, 0);
    // undefined op codes
    add_row(OP_RSVD6,  5,    32'hFFFF_FFFF, 1, 0, 32'h0, 0, 0);
    add_row(OP_RSVD7,  1023, 32'h8000_0000, 1, 0, 32'h0, 0, 0);
    add_row(OP_APPEND, 0,    32'h8000_0000, 1, 1, 32'h0, 0, 1);
    add_row(OP_APPEND, 1023, 32'h7FFF_FFFF, 1, 1, 32'h0, 0, 2);
    add_row(OP_INSERT, 0,    32'hFFFF_FFFF, 1, 1, 32'h0, 0, 3);
    // insert at the count acts as append
    add_row(OP_INSERT, 3,    32'h0000_0000, 1, 1, 32'h0, 0, 4);
    add_row(OP_INSERT, 1023, 32'h0000_0001, 1, 0, 32'h0, 0, 4);
    add_row(OP_GET,    0,    32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0, 4);
    // bad index on get and set
    add_row(OP_GET,    4,    32'h0000_0000, 1, 0, 32'h0, 0, 4);
    add_row(OP_GET,    1023, 32'h0000_0000, 1, 0, 32'h0, 0, 4);
    add_row(OP_GET,    2,    32'h0000_0000, 0, 0, 32'h0, 0, 0);
    add_row(OP_SET,    1,    32'h5555_5555, 0, 0, 32'h0, 0, 0);
    add_row(OP_SET,    1023, 32'h0000_0001, 1, 0, 32'h0, 0, 4);
    add_row(OP_FIND,   0,    32'h7FFF_FFFF, 0, 0, 32'h0, 0, 0);
    // value not found
    add_row(OP_FIND,   0,    32'h1234_5678, 1, 0, 32'h0, 0, 4);
    add_row(OP_APPEND, 0,    32'hFFFF_FFFF, 0, 0, 32'h0, 0, 0);
    add_row(OP_FIND,   0,    32'hFFFF_FFFF, 0, 0, 32'h0, 0, 0);
    add_row(OP_INSERT, 2,    32'hAAAA_AAAA, 0, 0, 32'h0, 0, 0);
    add_row(OP_REMOVE, 0,    32'h0000_0000, 0, 0, 32'h0, 0, 0);
    add_row(OP_REMOVE, 4,    32'h0000_0000, 0, 0, 32'h0, 0, 0);
    add_row(OP_REMOVE, 1023, 32'h0000_0000, 1, 0, 32'h0, 0, 4);

    // reset held low at the start, then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[k])
      send_item(dir_table[k].op, dir_table[k].index, dir_table[k].value,
                dir_table[k].pinned, dir_table[k].want);

    // random mix, list kept short so walks stay cheap
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      live = held_count;
      roll = $urandom_range(0, 99);
      if (roll < 20)      op = OP_APPEND;
      else if (roll < 35) op = OP_INSERT;
      else if (roll < 50) op = OP_SET;
      else if (roll < 65) op = OP_GET;
      else if (roll < 80) op = OP_REMOVE;
      else if (roll < 96) op = OP_FIND;
      else                op = ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
      // steer the count between a few and about a hundred
      if (live > 96 && (op == OP_APPEND || op == OP_INSERT) && $urandom_range(0, 9) < 7)
        op = OP_REMOVE;
      if (live < 4 && op == OP_REMOVE && $urandom_range(0, 1) == 0)
        op = OP_APPEND;
      if ($urandom_range(0, 6) == 0)  idx = IDX_W'($urandom_range(0, 1023));
      else if (op == OP_INSERT)       idx = IDX_W'($urandom_range(0, live));
      else if (live == 0)             idx = '0;
      else                            idx = IDX_W'($urandom_range(0, live - 1));
      if (op == OP_FIND && live > 0 && $urandom_range(0, 1) == 0)
        val = held_words[$urandom_range(0, live - 1)];
      else
        val = pick_value();
      send_item(op, idx, val, 1'b0, '0);
    end

    // last part: no idling
    idle_on <= 1'b0;
    wait_results();

    // top position and out-of-range cases
    send_item(OP_SET,    10'd1023, 32'h1357_9BDF, 1'b0, '0);
    send_item(OP_APPEND, 10'd0,    pick_value(),  1'b0, '0);
    send_item(OP_INSERT, 10'd0,    pick_value(),  1'b0, '0);
    send_item(OP_INSERT, 10'd1023, pick_value(),  1'b0, '0);
    send_item(OP_GET,    10'd1023, 32'h0,         1'b0, '0);
    send_item(OP_FIND,   10'd0,    32'h1357_9BDF, 1'b0, '0);
    send_item(OP_FIND,   10'd0,    $urandom,      1'b0, '0);
    send_item(OP_REMOVE, 10'd0,    32'h0,         1'b0, '0);
    send_item(OP_INSERT, 10'd0,    pick_value(),  1'b0, '0);
    send_item(OP_REMOVE, 10'd1023, 32'h0,         1'b0, '0);
    send_item(OP_APPEND, 10'd0,    pick_value(),  1'b0, '0);

    // a few random operations back to back
    for (n = 0; n < LAST_OPS; n++) begin
      case ($urandom_range(0, 5))
        0: op = OP_APPEND;
        1: op = OP_INSERT;
        2: op = OP_SET;
        3: op = OP_GET;
        4: op = OP_REMOVE;
        default: op = OP_FIND;
      endcase
      send_item(op, IDX_W'($urandom_range(0, 1023)), pick_value(), 1'b0, '0);
    end

    // drain, then give any stray result time to show up
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/iae_pkg.sv
design/iae_mem.sv
design/iae_seq.sv
design/indexed_array_engine_core.sv
verif/indexed_array_engine_core_test.sv
